FILE: src/block_download_link_engine_assert.svh
// Assertion macros for the block download link engine.
// Each macro samples on clock and is disabled while reset is high.
`ifndef BLOCK_DOWNLOAD_LINK_ENGINE_ASSERT_SVH
`define BLOCK_DOWNLOAD_LINK_ENGINE_ASSERT_SVH

// Antecedent in the same cycle implies the consequent.
`define BDL_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies the consequent in the next cycle.
`define BDL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bdl_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the CRC-8 step of the block download link engine.
// Used by bdl_parse, bdl_emit and block_download_link_engine.
package bdl_pkg;

   localparam int MAX_BLOCK = 512;
   localparam int SIZE_W    = $clog2(MAX_BLOCK + 1);

   localparam logic [7:0] CRC_POLY = 8'h69;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Input commands
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_BYTE    = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;
   localparam logic [1:0] CMD_ABORT   = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Block status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_COMPLETE = 3'd1;
   localparam logic [2:0] ST_TIMEOUT  = 3'd2;
   localparam logic [2:0] ST_CRC      = 3'd3;
   localparam logic [2:0] ST_WRONG    = 3'd4;
   localparam logic [2:0] ST_SIZE     = 3'd5;
   localparam logic [2:0] ST_FAILED   = 3'd6;
   localparam logic [2:0] ST_ABORTED  = 3'd7;

   // Register indexes on the CSR port
   localparam logic [2:0] REG_OPCODE     = 3'd0;
   localparam logic [2:0] REG_START_CODE = 3'd1;
   localparam logic [2:0] REG_ACK_CODE   = 3'd2;
   localparam logic [2:0] REG_HUNT_LIMIT = 3'd3;
   localparam logic [2:0] REG_RETRIES    = 3'd4;

   typedef struct packed {
      logic [7:0] request_opcode;
      logic [7:0] start_code;
      logic [7:0] ack_code;
      logic [9:0] ack_hunt_limit;
      logic [2:0] max_retries;
   } bdl_cfg_type;

   // Everything one input item asks the output side to send, in order:
   // data byte, status, then a 7-byte request frame.
   typedef struct packed {
      logic        data_vld;
      logic [7:0]  data;
      logic        status_vld;
      logic [2:0]  status;
      logic        req_vld;
      logic [7:0]  start_code;
      logic [7:0]  opcode;
      logic [8:0]  file_number;
      logic [15:0] block_number;
   } bdl_desc_type;

   function automatic logic [7:0] crc_step(input logic [7:0] crc_i, input logic [7:0] d_i);
      logic [7:0] c;
      logic [7:0] d;
      logic       top;
      c = crc_i;
      d = d_i;
      for (int i = 0; i < 8; i++) begin
         top = c[7] ^ d[7];
         c   = {c[6:0], 1'b0} ^ (top ? CRC_POLY : 8'h00);
         d   = {d[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

FILE: src/block_download_link_engine.sv
`timescale 1ns / 1ps
// Block download link engine: one command or link byte per req beat; results on rsp, one
// per beat, at most one per cycle unless rsp stalls. An item waits in the descriptor
// register, its results in the rsp output register; req_stall holds a new item until the
// held item's last result moves out. Data bytes and unretried timeouts give one result,
// a start the 7-byte request frame, a retried or next request a status and the frame.
// Synchronous reset loads reset values, idles the engine and empties both result stages.
module block_download_link_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_file_index,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_value,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "block_download_link_engine_assert.svh"

   bdl_pkg::bdl_cfg_type  cfg_ff;
   bdl_pkg::bdl_desc_type desc;
   logic                  desc_any;
   logic                  accept;
   logic                  csr_write;
   logic [2:0]            csr_index;
   logic                  rsp_is_status;
   logic                  rsp_is_data;
   logic                  rsp_is_byte;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.request_opcode <= 8'd0;
         cfg_ff.start_code     <= 8'd2;
         cfg_ff.ack_code       <= 8'd6;
         cfg_ff.ack_hunt_limit <= 10'd513;
         cfg_ff.max_retries    <= 3'd3;
      end else if (csr_write) begin
         case (csr_index)
            bdl_pkg::REG_OPCODE:     cfg_ff.request_opcode <= csr_pwdata[7:0];
            bdl_pkg::REG_START_CODE: cfg_ff.start_code     <= csr_pwdata[7:0];
            bdl_pkg::REG_ACK_CODE:   cfg_ff.ack_code       <= csr_pwdata[7:0];
            bdl_pkg::REG_HUNT_LIMIT: cfg_ff.ack_hunt_limit <= csr_pwdata[9:0];
            bdl_pkg::REG_RETRIES:    cfg_ff.max_retries    <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bdl_pkg::REG_OPCODE:     csr_prdata = 32'(cfg_ff.request_opcode);
         bdl_pkg::REG_START_CODE: csr_prdata = 32'(cfg_ff.start_code);
         bdl_pkg::REG_ACK_CODE:   csr_prdata = 32'(cfg_ff.ack_code);
         bdl_pkg::REG_HUNT_LIMIT: csr_prdata = 32'(cfg_ff.ack_hunt_limit);
         bdl_pkg::REG_RETRIES:    csr_prdata = 32'(cfg_ff.max_retries);
         default:                 csr_prdata = '0;
      endcase
   end

   assign accept = req_valid & ~req_stall;

   bdl_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_command),
      .file_index (req_file_index),
      .rx_byte    (req_rx_byte),
      .cfg        (cfg_ff),
      .desc       (desc),
      .desc_any   (desc_any)
   );

   bdl_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .desc       (desc),
      .desc_any   (desc_any),
      .busy       (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_kind   (rsp_kind),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   assign rsp_is_status = rsp_valid & (rsp_kind == bdl_pkg::KIND_STATUS);
   assign rsp_is_data   = rsp_valid & (rsp_kind == bdl_pkg::KIND_DATA);
   assign rsp_is_byte   = rsp_valid & (rsp_kind != bdl_pkg::KIND_STATUS);

   // a held descriptor always has a result in the output register next cycle
   `BDL_ASSERT_NEXT(a_stall_fills_output, req_stall, rsp_valid, "stall without pending result")
   `BDL_ASSERT_IMPLY(a_status_value_zero, rsp_is_status, rsp_value == 8'd0, "status value set")
   `BDL_ASSERT_IMPLY(a_byte_no_status, rsp_is_byte, rsp_status == bdl_pkg::ST_OK, "status set")
   `BDL_ASSERT_IMPLY(a_data_is_last, rsp_is_data, rsp_last, "data byte not last of its item")

endmodule

FILE: src/bdl_parse.sv
`timescale 1ns / 1ps
// Download protocol state: request, ACK hunt, reply parsing, retries.
// Depends on bdl_pkg; hands a result descriptor to bdl_emit per accepted beat.
module bdl_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           command,
   input  logic [7:0]           file_index,
   input  logic [7:0]           rx_byte,
   input  bdl_pkg::bdl_cfg_type cfg,
   output bdl_pkg::bdl_desc_type desc,
   output logic                 desc_any
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_HUNT,
      PH_SIZE_LO,
      PH_SIZE_HI,
      PH_BLK_LO,
      PH_BLK_HI,
      PH_DATA,
      PH_CRC
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [15:0]                block_number_ff, block_number_in;
   logic [2:0]                 error_count_ff, error_count_in;
   logic [9:0]                 hunt_count_ff, hunt_count_in;
   logic [7:0]                 crc_acc_ff, crc_acc_in;
   logic [bdl_pkg::SIZE_W-1:0] block_size_ff, block_size_in;
   logic [15:0]                rx_block_ff, rx_block_in;
   logic [bdl_pkg::SIZE_W-1:0] byte_index_ff, byte_index_in;
   logic [8:0]                 file_number_ff, file_number_in;

   logic        err_hit;
   logic [2:0]  err_code;
   logic        do_req;
   logic [15:0] size_full;
   logic [7:0]  crc_byte;

   always_comb begin
      phase_in        = phase_ff;
      block_number_in = block_number_ff;
      error_count_in  = error_count_ff;
      hunt_count_in   = hunt_count_ff;
      crc_acc_in      = crc_acc_ff;
      block_size_in   = block_size_ff;
      rx_block_in     = rx_block_ff;
      byte_index_in   = byte_index_ff;
      file_number_in  = file_number_ff;
      desc            = '0;
      err_hit         = 1'b0;
      err_code        = bdl_pkg::ST_OK;
      do_req          = 1'b0;
      size_full       = {rx_byte, block_size_ff[7:0]};
      crc_byte        = bdl_pkg::crc_step(crc_acc_ff, rx_byte);

      if (command == bdl_pkg::CMD_START) begin
         file_number_in  = 9'(file_index) + 9'd1;
         block_number_in = '0;
         error_count_in  = '0;
         do_req          = 1'b1;
      end else if (phase_ff != PH_IDLE) begin
         case (command)
            bdl_pkg::CMD_BYTE: begin
               case (phase_ff)
                  PH_HUNT: begin
                     if (hunt_count_ff >= cfg.ack_hunt_limit) begin
                        err_hit  = 1'b1;
                        err_code = bdl_pkg::ST_TIMEOUT;
                     end else begin
                        hunt_count_in = hunt_count_ff + 10'd1;
                        if (rx_byte == cfg.ack_code) begin
                           crc_acc_in = bdl_pkg::crc_step(bdl_pkg::CRC_INIT, rx_byte);
                           phase_in   = PH_SIZE_LO;
                        end
                     end
                  end
                  PH_SIZE_LO: begin
                     crc_acc_in    = crc_byte;
                     block_size_in = bdl_pkg::SIZE_W'(rx_byte);
                     phase_in      = PH_SIZE_HI;
                  end
                  PH_SIZE_HI: begin
                     crc_acc_in    = crc_byte;
                     block_size_in = size_full[bdl_pkg::SIZE_W-1:0];
                     // oversize is caught here; the rest of that reply is hunted through
                     if (size_full > 16'(bdl_pkg::MAX_BLOCK)) begin
                        err_hit  = 1'b1;
                        err_code = bdl_pkg::ST_SIZE;
                     end else begin
                        phase_in = PH_BLK_LO;
                     end
                  end
                  PH_BLK_LO: begin
                     crc_acc_in  = crc_byte;
                     rx_block_in = 16'(rx_byte);
                     phase_in    = PH_BLK_HI;
                  end
                  PH_BLK_HI: begin
                     crc_acc_in    = crc_byte;
                     rx_block_in   = {rx_byte, rx_block_ff[7:0]};
                     byte_index_in = '0;
                     phase_in      = (block_size_ff != '0) ? PH_DATA : PH_CRC;
                  end
                  PH_DATA: begin
                     crc_acc_in    = crc_byte;
                     desc.data_vld = 1'b1;
                     desc.data     = rx_byte;
                     byte_index_in = byte_index_ff + bdl_pkg::SIZE_W'(1);
                     if (byte_index_in >= block_size_ff) begin
                        phase_in = PH_CRC;
                     end
                  end
                  PH_CRC: begin
                     // wrong block wins over a bad CRC
                     if (rx_block_ff != block_number_ff) begin
                        err_hit  = 1'b1;
                        err_code = bdl_pkg::ST_WRONG;
                     end else if (crc_acc_ff != rx_byte) begin
                        err_hit  = 1'b1;
                        err_code = bdl_pkg::ST_CRC;
                     end else if (block_size_ff == '0) begin
                        desc.status_vld = 1'b1;
                        desc.status     = bdl_pkg::ST_COMPLETE;
                        phase_in        = PH_IDLE;
                     end else begin
                        block_number_in = block_number_ff + 16'd1;
                        error_count_in  = '0;
                        desc.status_vld = 1'b1;
                        desc.status     = bdl_pkg::ST_OK;
                        do_req          = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            bdl_pkg::CMD_TIMEOUT: begin
               err_hit  = 1'b1;
               err_code = bdl_pkg::ST_TIMEOUT;
            end
            bdl_pkg::CMD_ABORT: begin
               desc.status_vld = 1'b1;
               desc.status     = bdl_pkg::ST_ABORTED;
               phase_in        = PH_IDLE;
            end
            default: ;
         endcase
      end

      if (err_hit) begin
         desc.status_vld = 1'b1;
         if (error_count_ff >= cfg.max_retries) begin
            desc.status = bdl_pkg::ST_FAILED;
            phase_in    = PH_IDLE;
         end else begin
            error_count_in = error_count_ff + 3'd1;
            desc.status    = err_code;
            do_req         = 1'b1;
         end
      end

      if (do_req) begin
         desc.req_vld      = 1'b1;
         desc.start_code   = cfg.start_code;
         desc.opcode       = cfg.request_opcode;
         desc.file_number  = file_number_in;
         desc.block_number = block_number_in;
         phase_in          = PH_HUNT;
         hunt_count_in     = '0;
         crc_acc_in        = bdl_pkg::CRC_INIT;
      end

      desc_any = desc.data_vld | desc.status_vld | desc.req_vld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         block_number_ff <= '0;
         error_count_ff  <= '0;
         hunt_count_ff   <= '0;
         crc_acc_ff      <= bdl_pkg::CRC_INIT;
         block_size_ff   <= '0;
         rx_block_ff     <= '0;
         byte_index_ff   <= '0;
         file_number_ff  <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         block_number_ff <= block_number_in;
         error_count_ff  <= error_count_in;
         hunt_count_ff   <= hunt_count_in;
         crc_acc_ff      <= crc_acc_in;
         block_size_ff   <= block_size_in;
         rx_block_ff     <= rx_block_in;
         byte_index_ff   <= byte_index_in;
         file_number_ff  <= file_number_in;
      end
   end

endmodule

FILE: src/bdl_emit.sv
`timescale 1ns / 1ps
// Result sequencer: holds one descriptor and sends its results one beat each.
// Depends on bdl_pkg; the request frame CRC is built as the frame goes out.
module bdl_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  bdl_pkg::bdl_desc_type desc,
   input  logic                  desc_any,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_value,
   output logic [2:0]            rsp_status,
   output logic                  rsp_last
);

   // Positions in the result list of one descriptor
   localparam logic [3:0] SLOT_DATA   = 4'd0;
   localparam logic [3:0] SLOT_STATUS = 4'd1;
   localparam logic [3:0] SLOT_START  = 4'd2;
   localparam logic [3:0] SLOT_OPCODE = 4'd3;
   localparam logic [3:0] SLOT_FILE_L = 4'd4;
   localparam logic [3:0] SLOT_FILE_H = 4'd5;
   localparam logic [3:0] SLOT_BLK_L  = 4'd6;
   localparam logic [3:0] SLOT_BLK_H  = 4'd7;
   localparam logic [3:0] SLOT_CRC    = 4'd8;

   bdl_pkg::bdl_desc_type desc_ff;
   logic       desc_vld_ff, desc_vld_in;
   logic [3:0] step_ff, step_in;
   logic [7:0] crc_ff, crc_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic [1:0] kind_ff;
   logic [7:0] value_ff;
   logic [2:0] status_ff;
   logic       last_ff;

   logic [1:0] out_kind;
   logic [7:0] out_value;
   logic [2:0] out_status;
   logic [3:0] end_slot;
   logic [3:0] first_slot;
   logic       at_end;
   logic       move;
   logic       free;
   logic       take;

   always_comb begin
      out_kind   = bdl_pkg::KIND_TX;
      out_status = bdl_pkg::ST_OK;
      out_value  = '0;
      case (step_ff)
         SLOT_DATA: begin
            out_kind  = bdl_pkg::KIND_DATA;
            out_value = desc_ff.data;
         end
         SLOT_STATUS: begin
            out_kind   = bdl_pkg::KIND_STATUS;
            out_status = desc_ff.status;
         end
         SLOT_START:  out_value = desc_ff.start_code;
         SLOT_OPCODE: out_value = desc_ff.opcode;
         SLOT_FILE_L: out_value = desc_ff.file_number[7:0];
         SLOT_FILE_H: out_value = {7'd0, desc_ff.file_number[8]};
         SLOT_BLK_L:  out_value = desc_ff.block_number[7:0];
         SLOT_BLK_H:  out_value = desc_ff.block_number[15:8];
         SLOT_CRC:    out_value = crc_ff;
         default: ;
      endcase

      end_slot   = desc_ff.data_vld ? SLOT_DATA : (desc_ff.req_vld ? SLOT_CRC : SLOT_STATUS);
      first_slot = desc.data_vld ? SLOT_DATA : (desc.status_vld ? SLOT_STATUS : SLOT_START);
      at_end     = (step_ff == end_slot);

      move = desc_vld_ff & (~rsp_vld_ff | ~rsp_stall);
      free = move & at_end;
      busy = desc_vld_ff & ~free;
      take = load & desc_any;

      // frame CRC runs over the six header bytes as they leave
      crc_in = crc_ff;
      if (move && step_ff >= SLOT_START && step_ff < SLOT_CRC) begin
         crc_in = bdl_pkg::crc_step((step_ff == SLOT_START) ? bdl_pkg::CRC_INIT : crc_ff,
                                    out_value);
      end

      step_in = step_ff;
      if (take) begin
         step_in = first_slot;
      end else if (move) begin
         step_in = step_ff + 4'd1;
      end

      desc_vld_in = desc_vld_ff;
      if (take) begin
         desc_vld_in = 1'b1;
      end else if (free) begin
         desc_vld_in = 1'b0;
      end

      rsp_vld_in = rsp_vld_ff;
      if (move) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         desc_vld_ff <= desc_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      if (take) begin
         desc_ff <= desc;
      end
      step_ff <= step_in;
      crc_ff  <= crc_in;
      if (move) begin
         kind_ff   <= out_kind;
         value_ff  <= out_value;
         status_ff <= out_status;
         last_ff   <= at_end;
      end
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

endmodule

FILE: verif/block_download_link_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for block_download_link_engine: request frames, reply parsing,
// retries, aborts and CSR settings, checked beat by beat against an in-bench predictor.
// Depends on bdl_pkg (codes, register indexes, config struct) and the engine RTL.
module block_download_link_engine_tb;

   typedef enum logic [3:0] {
      LNK_IDLE, LNK_HUNT, LNK_SIZE_LO, LNK_SIZE_HI, LNK_BLK_LO, LNK_BLK_HI, LNK_DATA, LNK_CRC
   } link_phase_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] file_index;
      logic [7:0] rx_byte;
   } link_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [2:0] status;
      logic       last;
   } link_beat_type;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PRINT_LIMIT = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = bdl_pkg::CMD_ABORT;
   logic [7:0]  req_file_index = 8'h00;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_value;
   logic [2:0]  rsp_status;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = 5'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   block_download_link_engine u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_file_index (req_file_index),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   bdl_pkg::bdl_cfg_type link_cfg;
   link_phase_type eng_phase;
   logic [15:0]    eng_block;
   logic [2:0]     eng_errors;
   logic [9:0]     eng_hunt;
   logic [7:0]     eng_crc;
   logic [15:0]    eng_size;
   logic [15:0]    eng_rx_block;
   logic [9:0]     eng_index;
   logic [8:0]     eng_file;
   link_beat_type  item_beats[$];
   link_beat_type  due_beats[$];
   int             mismatch_count = 0;

   // CRC-8, MSB first: fold the byte in, then shift it out
   function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      repeat (8) r = r[7] ? ((r << 1) ^ bdl_pkg::CRC_POLY) : (r << 1);
      return r;
   endfunction

   function automatic void note_beat(input logic [1:0] kind, input logic [7:0] value,
                                     input logic [2:0] status);
      link_beat_type b;
      b.kind   = kind;
      b.value  = value;
      b.status = status;
      b.last   = 1'b0;
      item_beats = {item_beats, b};
   endfunction

   function automatic void note_request();
      logic [7:0] frame [6];
      logic [7:0] crc;
      frame[0] = link_cfg.start_code;
      frame[1] = link_cfg.request_opcode;
      frame[2] = eng_file[7:0];
      frame[3] = {7'd0, eng_file[8]};
      frame[4] = eng_block[7:0];
      frame[5] = eng_block[15:8];
      crc = bdl_pkg::CRC_INIT;
      foreach (frame[i]) begin
         note_beat(bdl_pkg::KIND_TX, frame[i], bdl_pkg::ST_OK);
         crc = crc8_fold(crc, frame[i]);
      end
      note_beat(bdl_pkg::KIND_TX, crc, bdl_pkg::ST_OK);
      eng_phase = LNK_HUNT;
      eng_hunt  = '0;
      eng_crc   = bdl_pkg::CRC_INIT;
   endfunction

   function automatic void note_block_error(input logic [2:0] code);
      if (eng_errors >= link_cfg.max_retries) begin
         note_beat(bdl_pkg::KIND_STATUS, 8'h00, bdl_pkg::ST_FAILED);
         eng_phase = LNK_IDLE;
      end else begin
         eng_errors = eng_errors + 3'd1;
         note_beat(bdl_pkg::KIND_STATUS, 8'h00, code);
         note_request();
      end
   endfunction

   function automatic void take_link_byte(input logic [7:0] b);
      case (eng_phase)
         LNK_HUNT: begin
            if (eng_hunt >= link_cfg.ack_hunt_limit) begin
               note_block_error(bdl_pkg::ST_TIMEOUT);
            end else begin
               eng_hunt = eng_hunt + 10'd1;
               if (b == link_cfg.ack_code) begin
                  eng_crc   = crc8_fold(bdl_pkg::CRC_INIT, b);
                  eng_phase = LNK_SIZE_LO;
               end
            end
         end
         LNK_SIZE_LO: begin
            eng_crc   = crc8_fold(eng_crc, b);
            eng_size  = {8'h00, b};
            eng_phase = LNK_SIZE_HI;
         end
         LNK_SIZE_HI: begin
            eng_crc        = crc8_fold(eng_crc, b);
            eng_size[15:8] = b;
            if (eng_size > bdl_pkg::MAX_BLOCK) note_block_error(bdl_pkg::ST_SIZE);
            else eng_phase = LNK_BLK_LO;
         end
         LNK_BLK_LO: begin
            eng_crc      = crc8_fold(eng_crc, b);
            eng_rx_block = {8'h00, b};
            eng_phase    = LNK_BLK_HI;
         end
         LNK_BLK_HI: begin
            eng_crc            = crc8_fold(eng_crc, b);
            eng_rx_block[15:8] = b;
            eng_index          = '0;
            eng_phase          = (eng_size != 16'd0) ? LNK_DATA : LNK_CRC;
         end
         LNK_DATA: begin
            eng_crc = crc8_fold(eng_crc, b);
            note_beat(bdl_pkg::KIND_DATA, b, bdl_pkg::ST_OK);
            eng_index = eng_index + 10'd1;
            if (eng_index >= eng_size) eng_phase = LNK_CRC;
         end
         LNK_CRC: begin
            // block number is judged before the CRC
            if (eng_rx_block != eng_block) begin
               note_block_error(bdl_pkg::ST_WRONG);
            end else if (eng_crc != b) begin
               note_block_error(bdl_pkg::ST_CRC);
            end else if (eng_size == 16'd0) begin
               note_beat(bdl_pkg::KIND_STATUS, 8'h00, bdl_pkg::ST_COMPLETE);
               eng_phase = LNK_IDLE;
            end else begin
               eng_block  = eng_block + 16'd1;
               eng_errors = '0;
               note_beat(bdl_pkg::KIND_STATUS, 8'h00, bdl_pkg::ST_OK);
               note_request();
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_link_results(input link_cmd_type c);
      item_beats.delete();
      if (c.command == bdl_pkg::CMD_START) begin
         eng_file   = {1'b0, c.file_index} + 9'd1;
         eng_block  = '0;
         eng_errors = '0;
         note_request();
      end else if (eng_phase != LNK_IDLE) begin
         if (c.command == bdl_pkg::CMD_BYTE) begin
            take_link_byte(c.rx_byte);
         end else if (c.command == bdl_pkg::CMD_TIMEOUT) begin
            note_block_error(bdl_pkg::ST_TIMEOUT);
         end else begin
            note_beat(bdl_pkg::KIND_STATUS, 8'h00, bdl_pkg::ST_ABORTED);
            eng_phase = LNK_IDLE;
         end
      end
      if (item_beats.size() != 0) item_beats[item_beats.size() - 1].last = 1'b1;
      due_beats = {due_beats, item_beats};
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: rsp %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus
   link_cmd_type link_items[$];
   int           queued_items = 0;
   bit           gen_active = 1'b0;
   logic [15:0]  gen_block = '0;
   int           gen_errors = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           stall_hold = 0;

   function automatic void queue_cmd(input logic [1:0] command, input logic [7:0] fidx,
                                     input logic [7:0] rx);
      link_cmd_type c;
      c.command    = command;
      c.file_index = fidx;
      c.rx_byte    = rx;
      link_items = {link_items, c};
      queued_items++;
   endfunction

   function automatic void queue_byte(input logic [7:0] b);
      queue_cmd(bdl_pkg::CMD_BYTE, 8'($urandom), b);
   endfunction

   function automatic void queue_other(input logic [1:0] command);
      queue_cmd(command, 8'($urandom), 8'($urandom));
   endfunction

   function automatic void queue_start(input logic [7:0] fidx);
      queue_cmd(bdl_pkg::CMD_START, fidx, 8'($urandom));
      gen_active = 1'b1;
      gen_block  = '0;
      gen_errors = 0;
   endfunction

   function automatic void queue_hunt_noise(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom_range(255));
         if (b == link_cfg.ack_code) b = ~b;
         queue_byte(b);
      end
   endfunction

   function automatic void queue_reply(input int noise, input logic [15:0] blk_size,
                                       input logic [15:0] blk, input bit bad_crc);
      logic [7:0] crc;
      logic [7:0] b;
      queue_hunt_noise(noise);
      crc = crc8_fold(bdl_pkg::CRC_INIT, link_cfg.ack_code);
      queue_byte(link_cfg.ack_code);
      crc = crc8_fold(crc, blk_size[7:0]);
      queue_byte(blk_size[7:0]);
      crc = crc8_fold(crc, blk_size[15:8]);
      queue_byte(blk_size[15:8]);
      // an oversize block is refused at its size high byte
      if (blk_size > bdl_pkg::MAX_BLOCK) return;
      crc = crc8_fold(crc, blk[7:0]);
      queue_byte(blk[7:0]);
      crc = crc8_fold(crc, blk[15:8]);
      queue_byte(blk[15:8]);
      for (int i = 0; i < blk_size; i++) begin
         b   = 8'($urandom);
         crc = crc8_fold(crc, b);
         queue_byte(b);
      end
      if (bad_crc) crc = crc ^ (8'h01 << $urandom_range(7));
      queue_byte(crc);
   endfunction

   function automatic void note_gen_error();
      gen_errors++;
      if (gen_errors > link_cfg.max_retries) gen_active = 1'b0;
   endfunction

   function automatic void queue_random_exchange();
      int          roll;
      int          noise_max;
      logic [15:0] blk_size;
      roll      = $urandom_range(99);
      noise_max = (link_cfg.ack_hunt_limit > 3) ? 2 : int'(link_cfg.ack_hunt_limit) - 1;
      if (!gen_active || roll < 6) begin
         queue_start(8'($urandom_range(255)));
         return;
      end
      roll = $urandom_range(99);
      if (roll < 55) begin
         blk_size = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
         queue_reply($urandom_range(0, noise_max), blk_size, gen_block, 1'b0);
         if (blk_size == 16'd0) begin
            gen_active = 1'b0;
         end else begin
            gen_block  = gen_block + 16'd1;
            gen_errors = 0;
         end
      end else if (roll < 64) begin
         queue_reply(0, 16'($urandom_range(0, 4)), gen_block, 1'b1);
         note_gen_error();
      end else if (roll < 71) begin
         queue_reply(0, 16'($urandom_range(0, 4)),
                     gen_block ^ 16'($urandom_range(1, 65535)), 1'b0);
         note_gen_error();
      end else if (roll < 77) begin
         queue_reply(0, 16'($urandom_range(513, 65535)), gen_block, 1'b0);
         note_gen_error();
      end else if (roll < 83) begin
         queue_other(bdl_pkg::CMD_TIMEOUT);
         note_gen_error();
      end else if (roll < 87) begin
         queue_other(bdl_pkg::CMD_ABORT);
         gen_active = 1'b0;
      end else if (roll < 93) begin
         // run the hunt past its limit where that is short; else plain line noise
         if (link_cfg.ack_hunt_limit <= 12) begin
            queue_hunt_noise(link_cfg.ack_hunt_limit);
            queue_byte(8'($urandom));
            note_gen_error();
         end else begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
         end
      end else begin
         // cut a reply short and let the link time out
         queue_byte(link_cfg.ack_code);
         repeat ($urandom_range(0, 3)) queue_byte(8'($urandom));
         queue_other(bdl_pkg::CMD_TIMEOUT);
         note_gen_error();
      end
   endfunction

   function automatic void queue_random_items(input int n);
      int goal;
      goal = queued_items + n;
      while (queued_items < goal) queue_random_exchange();
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         bdl_pkg::REG_OPCODE:     link_cfg.request_opcode = val[7:0];
         bdl_pkg::REG_START_CODE: link_cfg.start_code     = val[7:0];
         bdl_pkg::REG_ACK_CODE:   link_cfg.ack_code       = val[7:0];
         bdl_pkg::REG_HUNT_LIMIT: link_cfg.ack_hunt_limit = val[9:0];
         bdl_pkg::REG_RETRIES:    link_cfg.max_retries    = val[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_link(input logic [7:0] opcode, input logic [7:0] start_code,
                               input logic [7:0] ack, input logic [9:0] hunt_limit,
                               input logic [2:0] retries);
      csr_write(bdl_pkg::REG_OPCODE, {24'd0, opcode});
      csr_write(bdl_pkg::REG_START_CODE, {24'd0, start_code});
      csr_write(bdl_pkg::REG_ACK_CODE, {24'd0, ack});
      csr_write(bdl_pkg::REG_HUNT_LIMIT, {22'd0, hunt_limit});
      csr_write(bdl_pkg::REG_RETRIES, {29'd0, retries});
   endtask

   // wait for every queued beat to be taken and answered, then let the engine settle
   task automatic drain_link();
      do @(negedge clock);
      while (link_items.size() != 0 || req_valid || due_beats.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- driver
   logic req_taken = 1'b0;

   always @(negedge clock) begin
      link_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (link_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt            = link_items.pop_front();
            req_valid      <= 1'b1;
            req_command    <= nxt.command;
            req_file_index <= nxt.file_index;
            req_rx_byte    <= nxt.rx_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: a long hold-off first when asked, else random stalls
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold = stall_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      link_beat_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_beats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= PRINT_LIMIT)
                  $display("%0t: rsp beat with nothing expected: kind %0d value %0d status %0d",
                           $time, rsp_kind, rsp_value, rsp_status);
            end else begin
               want = due_beats.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("value", want.value, rsp_value);
               check_field("status", want.status, rsp_status);
               check_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && !req_stall)
            predict_link_results('{req_command, req_file_index, req_rx_byte});
         req_taken <= req_valid && !req_stall;
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      link_cfg = '{request_opcode: 8'h00, start_code: 8'h02, ack_code: 8'h06,
                   ack_hunt_limit: 10'd513, max_retries: 3'd3};
      eng_phase    = LNK_IDLE;
      eng_block    = '0;
      eng_errors   = '0;
      eng_hunt     = '0;
      eng_crc      = bdl_pkg::CRC_INIT;
      eng_size     = '0;
      eng_rx_block = '0;
      eng_index    = '0;
      eng_file     = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, no idling
      queue_byte(8'($urandom));
      queue_other(bdl_pkg::CMD_TIMEOUT);
      queue_other(bdl_pkg::CMD_ABORT);
      queue_start(8'hFF);
      queue_reply(0, 16'd1, 16'd0, 1'b0);
      queue_reply(0, 16'd513, 16'd1, 1'b0);
      queue_reply(0, 16'd0, 16'd1, 1'b1);
      queue_other(bdl_pkg::CMD_TIMEOUT);
      queue_other(bdl_pkg::CMD_ABORT);
      queue_start(8'h00);
      queue_reply(0, 16'd0, 16'd0, 1'b0);
      drain_link();

      // wide codes, longest hunt, most retries; sender gaps
      program_link(8'hFF, 8'h00, 8'hFF, 10'd1023, 3'd7);
      send_idle_pct = 46;
      rsp_stall_pct = 0;
      queue_start(8'($urandom_range(255)));
      // largest legal size passes the size check; drop that reply partway with an abort
      queue_byte(link_cfg.ack_code);
      queue_byte(8'(bdl_pkg::MAX_BLOCK));
      queue_byte(8'(bdl_pkg::MAX_BLOCK >> 8));
      queue_byte(8'h00);
      queue_byte(8'h00);
      repeat (4) queue_byte(8'($urandom));
      queue_other(bdl_pkg::CMD_ABORT);
      gen_active = 1'b0;
      queue_random_items(40);
      drain_link();

      // shortest hunt, no retries; receiver stalls after a long hold-off
      program_link(8'hA5, 8'h5A, 8'h00, 10'd1, 3'd0);
      send_idle_pct = 0;
      rsp_stall_pct = 46;
      @(posedge clock);
      stall_hold = 150;
      queue_random_items(40);
      drain_link();

      program_link(8'h3C, 8'hC3, 8'h55, 10'd3, 3'd1);
      send_idle_pct = 34;
      rsp_stall_pct = 34;
      queue_random_items(40);
      drain_link();

      // back to reset values
      program_link(8'h00, 8'h02, 8'h06, 10'd513, 3'd3);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      queue_random_items(40);
      drain_link();

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
